>>> src/table_code_bit_packer_defines.svh
// Assertion macros used by the table code bit packer back end
`ifndef TABLE_CODE_BIT_PACKER_DEFINES_SVH
`define TABLE_CODE_BIT_PACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define TCBP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence
`define TCBP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcbp_pkg.sv
// Types and constants of the table code bit packer
package tcbp_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int IDX_W         = 8;
    localparam int CODE_W        = 32;
    localparam int MAX_CODE_BITS = 32;
    localparam int LEN_W         = 6;
    localparam int CNT_W         = 6;
    localparam int ACC_W         = 40;
    localparam int CAP_W         = 16;
    localparam int TOTAL_W       = 20;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] CMD_LOAD_PAT = 2'd0;
    localparam logic [1:0] CMD_LOAD_LEN = 2'd1;
    localparam logic [1:0] CMD_ENCODE   = 2'd2;
    localparam logic [1:0] CMD_FINISH   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_AFTER_ERR = 2'd3;

    localparam logic [1:0] KIND_CODE = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    localparam logic [IDX_W-1:0] SYM_XOR     = 8'h80;
    localparam logic [7:0]       HEADER_BYTE = 8'h01;
    localparam logic [LEN_W-1:0] LEN_SAT     = 6'd63;
    localparam logic [CAP_W-1:0] CAP_RESET   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CODE_W-1:0]  pattern;
        logic [LEN_W-1:0]   len;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total;
    } t_entry;

endpackage

>>> src/tcbp_if.sv
// Handshake channel interfaces of the table code bit packer
interface tcbp_in_if import tcbp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [IDX_W-1:0]  table_index;
    logic [CODE_W-1:0] table_word;
    logic [7:0]        data_byte;

    modport source (output valid, command, table_index, table_word, data_byte, input ready);
    modport sink (input valid, command, table_index, table_word, data_byte, output ready);
endinterface

interface tcbp_out_if import tcbp_pkg::*;;
    logic               valid;
    logic               ready;
    logic               has_byte;
    logic [7:0]         out_byte;
    logic               is_last;
    logic [TOTAL_W-1:0] total_bits;
    logic [1:0]         status;

    modport source (output valid, has_byte, out_byte, is_last, total_bits, status, input ready);
    modport sink (input valid, has_byte, out_byte, is_last, total_bits, status, output ready);
endinterface

interface tcbp_cfg_if import tcbp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> src/table_code_bit_packer.sv
// Top level of the table code bit packer
//
//  channel  | modport | transfer moves
//  ---------+---------+----------------------------------------------------
//  i_in     | sink    | command, table_index, table_word, data_byte
//  o_out    | source  | has_byte, out_byte, is_last, total_bits, status
//  i_cfg    | sink    | output_capacity_bytes write data
//
// A load sends nothing to o_out. An encode sends one word per completed output byte, plus
// one for the header of a stream; a 32-bit code completes four bytes. An encode that
// reports an error status sends one word with no byte, a finish one or two (header, final).
// The output register of the back end sends one byte per cycle while o_out.ready is high.
// Reset is synchronous; tables are not cleared and stream state returns to zero.
// Output stalls fill the work queue before they reach i_in.ready.
module table_code_bit_packer import tcbp_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcbp_in_if.sink     i_in,
    tcbp_cfg_if.sink    i_cfg,
    tcbp_out_if.source  o_out
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    tcbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    tcbp_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    tcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_out       (o_out)
    );

endmodule

>>> src/tcbp_front.sv
// Front end: accept commands, hold the code tables, classify encodes
module tcbp_front import tcbp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcbp_in_if.sink      i_in,
    tcbp_cfg_if.sink     i_cfg,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output t_entry       o_push_entry
);

    logic [CODE_W-1:0]  r_pat_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]   r_len_mem [SYMBOL_COUNT];
    logic [CODE_W-1:0]  r_pat_rd;
    logic [LEN_W-1:0]   r_len_rd;
    logic               r_b_v;
    logic [1:0]         r_b_cmd;
    logic [TOTAL_W-1:0] r_payload;
    logic [TOTAL_W-1:0] n_payload;
    logic [1:0]         r_err;
    logic [1:0]         n_err;
    logic [CAP_W-1:0]   r_cap;

    logic               accept;
    logic               advance;
    logic [IDX_W-1:0]   sym;
    logic [LEN_W-1:0]   len_sat;
    logic [CAP_W-1:0]   cap_m1;
    logic [TOTAL_W:0]   limit;
    logic [TOTAL_W:0]   sum;
    logic [CODE_W-1:0]  mask;
    t_entry             entry;

    assign advance      = r_b_v && i_push_ready;
    assign i_in.ready   = !r_b_v || i_push_ready;
    assign accept       = i_in.valid && i_in.ready;
    assign i_cfg.ready  = 1'b1;
    assign sym          = i_in.data_byte ^ SYM_XOR;
    assign len_sat      = (i_in.table_word > CODE_W'(LEN_SAT)) ? LEN_SAT
                                                               : i_in.table_word[LEN_W-1:0];
    assign o_push_valid = r_b_v;
    assign o_push_entry = entry;

    always_ff @(posedge i_clk) begin
        if (accept && i_in.command == CMD_LOAD_PAT) begin
            r_pat_mem[i_in.table_index] <= i_in.table_word;
        end
        if (accept && i_in.command == CMD_LOAD_LEN) begin
            r_len_mem[i_in.table_index] <= len_sat;
        end
        if (accept && i_in.command == CMD_ENCODE) begin
            r_pat_rd <= r_pat_mem[sym];
            r_len_rd <= r_len_mem[sym];
        end
    end

    always_comb begin
        cap_m1    = r_cap - CAP_W'(1);
        limit     = (r_cap == '0) ? '0 : (TOTAL_W+1)'({cap_m1, 3'b000});
        sum       = {1'b0, r_payload} + (TOTAL_W+1)'(r_len_rd);
        mask      = ~({CODE_W{1'b1}} << r_len_rd);
        entry     = '0;
        n_payload = r_payload;
        n_err     = r_err;
        case (r_b_cmd)
            CMD_ENCODE: begin
                entry.kind = KIND_ERR;
                if (r_err != ST_OK) begin
                    entry.status = ST_AFTER_ERR;
                end else if (sum >= limit) begin
                    entry.status = ST_CAPACITY;
                    n_err        = ST_CAPACITY;
                end else if (r_len_rd > LEN_W'(MAX_CODE_BITS)) begin
                    entry.status = ST_TOO_LONG;
                    n_err        = ST_TOO_LONG;
                end else begin
                    entry.kind    = KIND_CODE;
                    entry.pattern = r_pat_rd & mask;
                    entry.len     = r_len_rd;
                    n_payload     = sum[TOTAL_W-1:0];
                end
            end
            CMD_FINISH: begin
                entry.kind   = KIND_FIN;
                entry.total  = r_payload + TOTAL_W'(8);
                entry.status = r_err;
                n_payload    = '0;
                n_err        = ST_OK;
            end
            default: begin
                entry = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v     <= 1'b0;
            r_payload <= '0;
            r_err     <= ST_OK;
            r_cap     <= CAP_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            if (advance) begin
                r_payload <= n_payload;
                r_err     <= n_err;
            end
            if (i_in.ready) begin
                r_b_v <= accept && (i_in.command == CMD_ENCODE ||
                                    i_in.command == CMD_FINISH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_cmd <= i_in.command;
        end
    end

endmodule

>>> src/tcbp_queue.sv
// Short queue of classified work between front and back ends
module tcbp_queue import tcbp_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_entry,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_entry
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_entry        r_mem [P_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != CW'(P_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> src/tcbp_back.sv
// Back end: pack code bits into bytes and drive the output register
`include "table_code_bit_packer_defines.svh"

module tcbp_back import tcbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_entry      i_pop_entry,
    tcbp_out_if.source  o_out
);

    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   n_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_hdr;
    logic               n_hdr;
    logic               r_tail_v;
    logic               n_tail_v;
    t_entry             r_tail;
    t_entry             n_tail;
    logic               r_out_v;
    logic               n_out_v;
    logic               r_has;
    logic [7:0]         r_byte;
    logic               r_last;
    logic [TOTAL_W-1:0] r_total;
    logic [1:0]         r_status;

    logic               out_free;
    logic               emit;
    logic               emit_final;
    logic               e_has;
    logic [7:0]         e_byte;
    logic               e_last;
    logic [TOTAL_W-1:0] e_total;
    logic [1:0]         e_status;
    logic               pop;

    assign out_free          = !r_out_v || o_out.ready;
    assign o_out.valid       = r_out_v;
    assign o_out.has_byte    = r_has;
    assign o_out.out_byte    = r_byte;
    assign o_out.is_last     = r_last;
    assign o_out.total_bits  = r_total;
    assign o_out.status      = r_status;
    assign o_pop_ready       = pop;

    always_comb begin
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_hdr      = r_hdr;
        n_tail_v   = r_tail_v;
        n_tail     = r_tail;
        emit       = 1'b0;
        emit_final = 1'b0;
        e_has      = 1'b0;
        e_byte     = '0;
        e_last     = 1'b0;
        e_total    = '0;
        e_status   = ST_OK;
        pop        = 1'b0;

        if (out_free) begin
            if (r_cnt >= CNT_W'(8)) begin
                emit  = 1'b1;
                e_has = 1'b1;
                if (!r_hdr) begin
                    e_byte = HEADER_BYTE;
                    n_hdr  = 1'b1;
                end else begin
                    e_byte = r_acc[7:0];
                    n_acc  = r_acc >> 8;
                    n_cnt  = r_cnt - CNT_W'(8);
                end
            end else if (r_tail_v) begin
                emit = 1'b1;
                if (r_tail.kind == KIND_FIN && !r_hdr) begin
                    e_has  = 1'b1;
                    e_byte = HEADER_BYTE;
                    n_hdr  = 1'b1;
                end else begin
                    n_tail_v = 1'b0;
                    e_status = r_tail.status;
                    if (r_tail.kind == KIND_FIN) begin
                        emit_final = 1'b1;
                        e_has      = r_cnt != '0;
                        e_byte     = (r_cnt != '0) ? r_acc[7:0] : 8'h00;
                        e_last     = 1'b1;
                        e_total    = r_tail.total;
                        n_acc      = '0;
                        n_cnt      = '0;
                        n_hdr      = 1'b0;
                    end
                end
            end
        end

        if (i_pop_valid && !r_tail_v && n_cnt < CNT_W'(8)) begin
            pop = 1'b1;
            case (i_pop_entry.kind)
                KIND_CODE: begin
                    n_acc = n_acc | (ACC_W'(i_pop_entry.pattern) << n_cnt[2:0]);
                    n_cnt = n_cnt + CNT_W'(i_pop_entry.len);
                end
                default: begin
                    n_tail_v = 1'b1;
                    n_tail   = i_pop_entry;
                end
            endcase
        end

        if (emit) begin
            n_out_v = 1'b1;
        end else if (o_out.ready) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_hdr    <= 1'b0;
            r_tail_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_hdr    <= n_hdr;
            r_tail_v <= n_tail_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        if (emit) begin
            r_has    <= e_has;
            r_byte   <= e_byte;
            r_last   <= e_last;
            r_total  <= e_total;
            r_status <= e_status;
        end
    end

    `TCBP_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt < CNT_W'(ACC_W), "bit count overflow")
    `TCBP_ASSERT_ALWAYS(a_acc_clean, i_clk, i_rst_n, (r_acc >> r_cnt) == '0, "stray accumulator bits")
    `TCBP_ASSERT_NEXT(a_final_clear, i_clk, i_rst_n, emit_final, r_cnt == '0 && !r_hdr, "stream not cleared")
    `TCBP_ASSERT_NEXT(a_pop_tail, i_clk, i_rst_n, pop && i_pop_entry.kind != KIND_CODE, r_tail_v, "tail lost")

endmodule

>>> verif/table_code_bit_packer_test.sv
// Self-checking table code bit packer bench: code, error, capacity, random and stall tests
module table_code_bit_packer_test;
    import tcbp_pkg::*;

    typedef struct packed {
        logic               has_byte;
        logic [7:0]         out_byte;
        logic               is_last;
        logic [TOTAL_W-1:0] total_bits;
        logic [1:0]         status;
    } t_stream_word;

    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    tcbp_in_if  in_ch ();
    tcbp_cfg_if cfg_ch ();
    tcbp_out_if out_ch ();

    table_code_bit_packer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [CODE_W-1:0] code_pattern [SYMBOL_COUNT];
    logic [LEN_W-1:0]  code_len [SYMBOL_COUNT];
    bit                pattern_loaded [SYMBOL_COUNT];
    bit                len_loaded [SYMBOL_COUNT];
    logic [63:0]       pending_bits;
    int unsigned       pending_count;
    int unsigned       payload_bits;
    bit                header_done;
    logic [1:0]        sticky_status;
    logic [CAP_W-1:0]  capacity;

    t_stream_word expected_words [$];
    t_stream_word want_word;
    int           errors;
    int           src_idle_pct;
    int           snk_idle_pct;
    bit           hold_on;
    event         hold_go;

    always #2 clk = ~clk;

    initial begin
        #800000;
        $display("[table_code_bit_packer] ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    function automatic void push_word(logic has, logic [7:0] value, logic last,
                                      logic [TOTAL_W-1:0] total, logic [1:0] st);
        t_stream_word w;
        w.has_byte   = has;
        w.out_byte   = value;
        w.is_last    = last;
        w.total_bits = total;
        w.status     = st;
        expected_words.push_back(w);
    endfunction

    function automatic void clear_stream_state();
        pending_bits  = '0;
        pending_count = 0;
        payload_bits  = 0;
        header_done   = 1'b0;
        sticky_status = ST_OK;
    endfunction

    function automatic void predict_item(logic [1:0] cmd, logic [7:0] idx, logic [31:0] word,
                                         logic [7:0] data);
        logic [7:0]         sym;
        int unsigned        len;
        int unsigned        limit;
        logic [63:0]        mask;
        logic [TOTAL_W-1:0] total;
        sym = data ^ SYM_XOR;
        case (cmd)
            CMD_LOAD_PAT: begin
                code_pattern[idx]   = word;
                pattern_loaded[idx] = 1'b1;
            end
            CMD_LOAD_LEN: begin
                code_len[idx]   = (word > 63) ? LEN_SAT : word[LEN_W-1:0];
                len_loaded[idx] = 1'b1;
            end
            CMD_ENCODE: begin
                len   = code_len[sym];
                limit = (capacity >= 1) ? (int'(capacity) - 1) * 8 : 0;
                if (sticky_status != ST_OK) begin
                    push_word(1'b0, 8'h00, 1'b0, '0, ST_AFTER_ERR);
                end else if (payload_bits + len >= limit) begin
                    sticky_status = ST_CAPACITY;
                    push_word(1'b0, 8'h00, 1'b0, '0, ST_CAPACITY);
                end else if (len > MAX_CODE_BITS) begin
                    sticky_status = ST_TOO_LONG;
                    push_word(1'b0, 8'h00, 1'b0, '0, ST_TOO_LONG);
                end else begin
                    mask = (len >= 32) ? 64'hFFFF_FFFF : ((64'd1 << len) - 64'd1);
                    pending_bits  |= ({32'd0, code_pattern[sym]} & mask) << (pending_count & 7);
                    pending_count += len;
                    payload_bits  += len;
                    while (pending_count >= 8) begin
                        if (!header_done) begin
                            push_word(1'b1, HEADER_BYTE, 1'b0, '0, ST_OK);
                            header_done = 1'b1;
                        end
                        push_word(1'b1, pending_bits[7:0], 1'b0, '0, ST_OK);
                        pending_bits  = pending_bits >> 8;
                        pending_count -= 8;
                    end
                    pending_bits &= 64'hFF_FFFF_FFFF;
                end
            end
            default: begin
                total = TOTAL_W'(payload_bits + 8);
                if (!header_done)
                    push_word(1'b1, HEADER_BYTE, 1'b0, '0, ST_OK);
                if (pending_count > 0)
                    push_word(1'b1, pending_bits[7:0], 1'b1, total, sticky_status);
                else
                    push_word(1'b0, 8'h00, 1'b1, total, sticky_status);
                clear_stream_state();
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t unexpected output transfer: expected none actual out_byte %0h",
                         $time, out_ch.out_byte);
            end else begin
                want_word = expected_words.pop_front();
                check_field("has_byte", want_word.has_byte, out_ch.has_byte);
                check_field("out_byte", want_word.out_byte, out_ch.out_byte);
                check_field("is_last", want_word.is_last, out_ch.is_last);
                check_field("total_bits", want_word.total_bits, out_ch.total_bits);
                check_field("status", want_word.status, out_ch.status);
            end
        end
        if (hold_on) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] idx, logic [31:0] word,
                             logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.table_index <= idx;
        in_ch.table_word  <= word;
        in_ch.data_byte   <= data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_item(cmd, idx, word, data);
    endtask

    task automatic load_code(logic [7:0] sym, logic [31:0] pattern, logic [31:0] len_word);
        send_item(CMD_LOAD_PAT, sym, pattern, 8'($urandom));
        send_item(CMD_LOAD_LEN, sym, len_word, 8'($urandom));
    endtask

    task automatic encode_sym(logic [7:0] sym);
        send_item(CMD_ENCODE, 8'($urandom), $urandom, sym ^ SYM_XOR);
    endtask

    task automatic finish_stream();
        send_item(CMD_FINISH, 8'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        capacity = value;
    endtask

    function automatic int pick_symbol(bit want_bad);
        int start;
        int s;
        start = $urandom_range(0, SYMBOL_COUNT - 1);
        for (int k = 0; k < SYMBOL_COUNT; k++) begin
            s = (start + k) % SYMBOL_COUNT;
            if (pattern_loaded[s] && len_loaded[s] && ((code_len[s] > MAX_CODE_BITS) == want_bad))
                return s;
        end
        return -1;
    endfunction

    function automatic logic [31:0] rand_len_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom;
        else if (r < 12)
            return $urandom_range(MAX_CODE_BITS + 1, 63);
        else if (r < 17)
            return 0;
        return $urandom_range(1, MAX_CODE_BITS);
    endfunction

    task automatic test_code_extremes();
        finish_stream();
        load_code(8'h00, 32'hFFFF_FFFF, MAX_CODE_BITS);
        load_code(8'hFF, 32'h0000_0000, 1);
        load_code(8'h7F, 32'hA5A5_A5A5, 0);
        load_code(8'h55, 32'h1234_5655, 7);
        encode_sym(8'h00);
        encode_sym(8'hFF);
        encode_sym(8'h7F);
        encode_sym(8'h55);
        finish_stream();
    endtask

    task automatic test_error_cases();
        load_code(8'h10, $urandom, 32'hFFFF_FFFF);
        encode_sym(8'h10);
        encode_sym(8'h00);
        finish_stream();
    endtask

    task automatic test_capacity_limits();
        set_capacity(2);
        encode_sym(8'hFF);
        encode_sym(8'h55);
        finish_stream();
        set_capacity(1);
        encode_sym(8'hFF);
        finish_stream();
        set_capacity(CAP_RESET);
    endtask

    task automatic test_random_streams(int src_pct, int snk_pct, int n_items);
        int sent;
        int body;
        int r;
        int s;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: set_capacity(CAP_RESET);
                    2: set_capacity(2);
                    3: set_capacity(CAP_W'($urandom_range(3, 12)));
                    default: set_capacity(CAP_W'($urandom_range(13, 200)));
                endcase
            end
            body = $urandom_range(6, 36);
            repeat (body) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_item(CMD_LOAD_PAT, 8'($urandom), $urandom, 8'($urandom));
                end else if (r < 16) begin
                    send_item(CMD_LOAD_LEN, 8'($urandom), rand_len_word(), 8'($urandom));
                end else begin
                    s = pick_symbol(r < 20);
                    if (s < 0)
                        s = pick_symbol(1'b0);
                    if (s < 0) begin
                        s = $urandom_range(0, SYMBOL_COUNT - 1);
                        load_code(8'(s), $urandom, $urandom_range(1, MAX_CODE_BITS));
                        sent += 2;
                    end
                    encode_sym(8'(s));
                end
                sent++;
            end
            finish_stream();
            sent++;
        end
    endtask

    task automatic test_backpressure();
        set_capacity(CAP_RESET);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        -> hold_go;
        load_code(8'h00, $urandom, MAX_CODE_BITS);
        repeat (24) encode_sym(8'h00);
        finish_stream();
    endtask

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_LOAD_PAT;
        in_ch.table_index = '0;
        in_ch.table_word  = '0;
        in_ch.data_byte   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        out_ch.ready      = 1'b0;
        errors            = 0;
        src_idle_pct      = 12;
        snk_idle_pct      = 63;
        capacity          = CAP_RESET;
        clear_stream_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_code_extremes();
        test_error_cases();
        test_capacity_limits();
        test_random_streams(12, 63, 120);
        test_random_streams(63, 12, 120);
        test_random_streams(0, 0, 120);
        test_backpressure();

        wait_idle();
        if (errors == 0 && expected_words.size() == 0) begin
            $display("[table_code_bit_packer] OK");
        end else begin
            $display("[table_code_bit_packer] ERROR");
        end
        $finish;
    end

endmodule
